>>> rtl/core/frt_pkg.sv
// frt_pkg: shared types, verdict codes and header constants of the fragment tracker
// no dependencies

package frt_pkg;

  localparam int unsigned SIGN_BYTES   = 64;
  localparam int unsigned HEADER_BYTES = 1 + SIGN_BYTES + 12;

  localparam int unsigned LEN_W   = 12;
  localparam int unsigned TYPE_W  = 8;
  localparam int unsigned ID_W    = 64;
  localparam int unsigned FRAG_W  = 8;
  localparam int unsigned VERD_W  = 4;
  localparam int unsigned TOTAL_W = 16;
  localparam int unsigned PAY_W   = 11;

  localparam logic [VERD_W-1:0] V_OK        = 4'd0;
  localparam logic [VERD_W-1:0] V_LENGTH    = 4'd1;
  localparam logic [VERD_W-1:0] V_SIGNATURE = 4'd2;
  localparam logic [VERD_W-1:0] V_ID        = 4'd3;
  localparam logic [VERD_W-1:0] V_ZERO      = 4'd4;
  localparam logic [VERD_W-1:0] V_INDEX     = 4'd5;
  localparam logic [VERD_W-1:0] V_TYPE      = 4'd6;
  localparam logic [VERD_W-1:0] V_COUNT     = 4'd7;
  localparam logic [VERD_W-1:0] V_DUP       = 4'd8;
  localparam logic [VERD_W-1:0] V_TOO_LARGE = 4'd9;

  typedef struct packed {
    logic [LEN_W-1:0]  packet_length;
    logic              signature_valid;
    logic [TYPE_W-1:0] packet_type;
    logic [ID_W-1:0]   header_id;
    logic [FRAG_W-1:0] frag_index;
    logic [FRAG_W-1:0] frag_count;
  } in_item_t;

  typedef struct packed {
    logic [VERD_W-1:0]  verdict;
    logic               complete;
    logic [TOTAL_W-1:0] total_bytes;
  } out_item_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  latched_type;
    logic [FRAG_W-1:0]  latched_total;
    logic [FRAG_W-1:0]  received_count;
    logic [TOTAL_W-1:0] byte_total;
    logic               finished;
  } state_t;

  typedef struct packed {
    logic               latch;
    logic [TYPE_W-1:0]  latch_type;
    logic [FRAG_W-1:0]  latch_total;
    logic               accept;
    logic [FRAG_W-1:0]  count;
    logic [TOTAL_W-1:0] byte_total;
    logic               finish;
  } upd_t;

endpackage

>>> rtl/core/frt_in_if.sv
// frt_in_if: valid/ready channel carrying one fragment header request
// depends on frt_pkg for field widths

interface frt_in_if;
  logic                       valid;
  logic                       ready;
  logic [frt_pkg::LEN_W-1:0]  packet_length;
  logic                       signature_valid;
  logic [frt_pkg::TYPE_W-1:0] packet_type;
  logic [frt_pkg::ID_W-1:0]   header_id;
  logic [frt_pkg::FRAG_W-1:0] frag_index;
  logic [frt_pkg::FRAG_W-1:0] frag_count;

  modport source (
    output valid, packet_length, signature_valid, packet_type, header_id,
           frag_index, frag_count,
    input  ready
  );
  modport sink (
    input  valid, packet_length, signature_valid, packet_type, header_id,
           frag_index, frag_count,
    output ready
  );
endinterface

>>> rtl/core/frt_out_if.sv
// frt_out_if: valid/ready channel carrying one verdict request
// depends on frt_pkg for field widths

interface frt_out_if;
  logic                        valid;
  logic                        ready;
  logic [frt_pkg::VERD_W-1:0]  verdict;
  logic                        complete;
  logic [frt_pkg::TOTAL_W-1:0] total_bytes;

  modport source (
    output valid, verdict, complete, total_bytes,
    input  ready
  );
  modport sink (
    input  valid, verdict, complete, total_bytes,
    output ready
  );
endinterface

>>> rtl/core/frt_check.sv
// frt_check: ordered header checks, completion test and state update for one fragment
// depends on frt_pkg

module frt_check #(
  parameter int unsigned FRAG_PAYLOAD_MAX = 1024,
  parameter int unsigned FRAG_SLOTS       = 16
) (
  input  frt_pkg::in_item_t             item,
  input  frt_pkg::state_t               st,
  input  logic [FRAG_SLOTS-1:0]         received_map,
  input  logic [frt_pkg::ID_W-1:0]      request_id,
  output frt_pkg::out_item_t            res,
  output frt_pkg::upd_t                 upd
);

  localparam int unsigned IDX_W = (FRAG_SLOTS > 1) ? $clog2(FRAG_SLOTS) : 1;
  localparam logic [frt_pkg::LEN_W:0] LEN_MIN = (frt_pkg::LEN_W + 1)'(frt_pkg::HEADER_BYTES);
  localparam logic [frt_pkg::LEN_W:0] LEN_MAX =
    (frt_pkg::LEN_W + 1)'(frt_pkg::HEADER_BYTES + FRAG_PAYLOAD_MAX);
  localparam logic [frt_pkg::FRAG_W:0] SLOTS_LIM = (frt_pkg::FRAG_W + 1)'(FRAG_SLOTS);

  logic [frt_pkg::LEN_W:0]     len_ext;
  logic                        in_window;
  logic                        count_big;
  logic                        not_latched;
  logic [frt_pkg::TYPE_W-1:0]  eff_type;
  logic [frt_pkg::FRAG_W-1:0]  eff_total;
  logic [IDX_W-1:0]            idx;
  logic                        dup;
  logic [frt_pkg::PAY_W-1:0]   pay;
  logic [frt_pkg::TOTAL_W:0]   sum;
  logic [frt_pkg::TOTAL_W-1:0] total_sat;
  logic [frt_pkg::FRAG_W-1:0]  count_inc;
  logic [frt_pkg::VERD_W-1:0]  verdict;
  logic                        reach_latch;

  assign len_ext     = {1'b0, item.packet_length};
  assign in_window   = (len_ext >= LEN_MIN) && (len_ext <= LEN_MAX);
  assign count_big   = {1'b0, item.frag_count} > SLOTS_LIM;
  assign not_latched = (st.latched_total == '0);
  assign eff_type    = not_latched ? item.packet_type : st.latched_type;
  assign eff_total   = not_latched ? item.frag_count : st.latched_total;
  assign idx         = item.frag_index[IDX_W-1:0];
  assign dup         = received_map[idx];
  assign pay         = frt_pkg::PAY_W'(item.packet_length -
                                       frt_pkg::LEN_W'(frt_pkg::HEADER_BYTES));
  assign sum         = {1'b0, st.byte_total} + (frt_pkg::TOTAL_W + 1)'(pay);
  assign total_sat   = sum[frt_pkg::TOTAL_W] ? '1 : sum[frt_pkg::TOTAL_W-1:0];
  assign count_inc   = st.received_count + 8'd1;

  always_comb begin
    reach_latch = 1'b0;
    if (!in_window) begin
      verdict = frt_pkg::V_LENGTH;
    end else if (!item.signature_valid) begin
      verdict = frt_pkg::V_SIGNATURE;
    end else if (st.finished || (item.header_id != request_id)) begin
      verdict = frt_pkg::V_ID;
    end else if (item.frag_count == '0) begin
      verdict = frt_pkg::V_ZERO;
    end else if (item.frag_index >= item.frag_count) begin
      verdict = frt_pkg::V_INDEX;
    end else if (count_big) begin
      verdict = frt_pkg::V_TOO_LARGE;
    end else begin
      reach_latch = 1'b1;
      if (item.packet_type != eff_type) begin
        verdict = frt_pkg::V_TYPE;
      end else if (item.frag_count != eff_total) begin
        verdict = frt_pkg::V_COUNT;
      end else if (dup) begin
        verdict = frt_pkg::V_DUP;
      end else begin
        verdict = frt_pkg::V_OK;
      end
    end
  end

  always_comb begin
    upd.latch       = reach_latch && not_latched;
    upd.latch_type  = item.packet_type;
    upd.latch_total = item.frag_count;
    upd.accept      = (verdict == frt_pkg::V_OK);
    upd.count       = count_inc;
    upd.byte_total  = total_sat;
    upd.finish      = upd.accept && (count_inc == eff_total);
    res.verdict     = verdict;
    res.complete    = upd.finish;
    res.total_bytes = upd.finish ? total_sat : '0;
  end

endmodule

>>> rtl/core/frt_state.sv
// frt_state: tracker registers (received bitmap, latched type and count, totals)
// depends on frt_pkg

module frt_state #(
  parameter int unsigned FRAG_SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [frt_pkg::FRAG_W-1:0]  frag_index,
  input  frt_pkg::upd_t               upd,
  output frt_pkg::state_t             st,
  output logic [FRAG_SLOTS-1:0]       received_map
);

  localparam int unsigned IDX_W = (FRAG_SLOTS > 1) ? $clog2(FRAG_SLOTS) : 1;

  logic [IDX_W-1:0] idx;

  assign idx = frag_index[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= '0;
      received_map <= '0;
    end else if (en) begin
      if (upd.latch) begin
        st.latched_type  <= upd.latch_type;
        st.latched_total <= upd.latch_total;
      end
      if (upd.accept) begin
        received_map[idx] <= 1'b1;
        st.received_count <= upd.count;
        st.byte_total     <= upd.byte_total;
      end
      if (upd.finish) begin
        st.finished <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/fragment_reassembly_tracker_unit.sv
// fragment_reassembly_tracker_unit: top level of the response fragment tracker
// depends on frt_pkg, frt_in_if, frt_out_if, frt_check, frt_state
// a request is registered in the input stage, checked there, and its verdict is registered in the result register
// throughput: one fragment per cycle while results are taken; the input stage stalls while a result is held
// reset (rst, synchronous): clears bitmap, latches, totals, request id and both stages

module fragment_reassembly_tracker_unit #(
  parameter int unsigned FRAG_PAYLOAD_MAX = 1024,
  parameter int unsigned FRAG_SLOTS       = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  frt_in_if.sink                     frag,
  frt_out_if.source                  result,
  input  logic                       cfg_wr_en,
  input  logic [frt_pkg::ID_W-1:0]   cfg_wr_data
);

  logic [frt_pkg::ID_W-1:0] request_id;
  logic                     s1_valid;
  frt_pkg::in_item_t        s1_item;
  logic                     advance;
  logic                     out_valid;
  frt_pkg::out_item_t       out_item;
  frt_pkg::out_item_t       res;
  frt_pkg::upd_t            upd;
  frt_pkg::state_t          st;
  logic [FRAG_SLOTS-1:0]    received_map;

  assign advance    = s1_valid && (!out_valid || result.ready);
  assign frag.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      request_id <= '0;
    end else if (cfg_wr_en) begin
      request_id <= cfg_wr_data;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frag.ready) begin
      s1_valid <= frag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frag.valid && frag.ready) begin
      s1_item.packet_length   <= frag.packet_length;
      s1_item.signature_valid <= frag.signature_valid;
      s1_item.packet_type     <= frag.packet_type;
      s1_item.header_id       <= frag.header_id;
      s1_item.frag_index      <= frag.frag_index;
      s1_item.frag_count      <= frag.frag_count;
    end
  end

  frt_check #(
    .FRAG_PAYLOAD_MAX (FRAG_PAYLOAD_MAX),
    .FRAG_SLOTS       (FRAG_SLOTS)
  ) u_check (
    .item         (s1_item),
    .st           (st),
    .received_map (received_map),
    .request_id   (request_id),
    .res          (res),
    .upd          (upd)
  );

  frt_state #(
    .FRAG_SLOTS (FRAG_SLOTS)
  ) u_state (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .frag_index   (s1_item.frag_index),
    .upd          (upd),
    .st           (st),
    .received_map (received_map)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

  assign result.valid       = out_valid;
  assign result.verdict     = out_item.verdict;
  assign result.complete    = out_item.complete;
  assign result.total_bytes = out_item.total_bytes;

  a_complete_ok: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.complete |-> result.verdict == frt_pkg::V_OK)
    else $error("completion reported on a rejected fragment");

  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.complete |-> result.total_bytes == '0)
    else $error("byte total shown without completion");

  a_no_accept_after_finish: assert property (@(posedge clk) disable iff (rst)
    advance && st.finished |-> res.verdict != frt_pkg::V_OK)
    else $error("fragment accepted after completion");

  a_map_count: assert property (@(posedge clk) disable iff (rst)
    $countones(received_map) == int'(st.received_count))
    else $error("bitmap population differs from received count");

endmodule
